// File: rtl/core/worst_fit_block_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Worst-fit allocator assertion macros
// Shared assertion shorthands for the allocator core. Each macro samples on
// the rising edge of clk and is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WORST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wfba_pkg.sv
// ----------------------------------------------------------------------------
// Worst-fit allocator package
// Fixed field widths, operation and status codes, and the control bundle
// shared by the allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfba_pkg;

    // Fixed widths of the external fields.
    localparam int FUNC_W    = 1;
    localparam int IDX_IN_W  = 5;
    localparam int SIZE_IN_W = 16;
    localparam int STATUS_W  = 2;
    localparam int CHOSEN_W  = 5;
    localparam int LEFT_W    = 16;
    localparam int CFG_W     = 6;

    // Reset value of the block count register.
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    // Request function codes on the input.
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

    // Classified operation codes carried through the queue.
    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD  = 2'd0;
    localparam op_t OP_SKIP  = 2'd1;
    localparam op_t OP_ALLOC = 2'd2;
    localparam int  OP_W     = 2;

    // Result status codes.
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_LOADED  = 2'd0;
    localparam status_t ST_GRANTED = 2'd1;
    localparam status_t ST_NOFIT   = 2'd2;

    // Reasons for the front end to hold off new requests.
    typedef struct packed {
        logic q_full;
        logic clearing;
    } hold_t;

endpackage

// File: rtl/core/worst_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// Worst-fit block allocator core
// Top level: front end, command queue and execution engine with the table.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken on a rising edge with start high and busy low. With
// func low it loads size into table entry block_index and frees that entry;
// with func high it asks for a block of at least size and gets the free
// block with the largest leftover below the configured block count.
// Every request yields one result: done is high for exactly one cycle with
// status, chosen_block and leftover. The receiver cannot stall results.
// The table scan reads one entry per cycle through one read port. The
// engine starts the next request only after a result, so it takes no
// new request from the queue before the last one is answered.
// A two-entry queue takes further requests while the engine works; busy
// rises when it is full. cfg_we writes cfg_data to the block count; the
// user must write it only while the block is idle, which the block itself
// does not enforce. After reset the used marks are cleared by a pass over
// all NUM_BLOCKS entries during which busy is high; the count resets to 32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "worst_fit_block_allocator_core_macros.svh"

module worst_fit_block_allocator_core #(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [wfba_pkg::FUNC_W-1:0]    func,
    input  logic [wfba_pkg::IDX_IN_W-1:0]  block_index,
    input  logic [wfba_pkg::SIZE_IN_W-1:0] size,
    input  logic                           cfg_we,
    input  logic [wfba_pkg::CFG_W-1:0]     cfg_data,
    output logic                           done,
    output logic [wfba_pkg::STATUS_W-1:0]  status,
    output logic [wfba_pkg::CHOSEN_W-1:0]  chosen_block,
    output logic [wfba_pkg::LEFT_W-1:0]    leftover
);
    import wfba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int QW    = OP_W + IDX_W + SIZE_BITS;

    hold_t         hold;
    logic          push;
    logic [QW-1:0] push_data;
    logic [QW-1:0] q_rdata;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          clearing;
    logic          no_grant;
    logic          fields_zero;

    assign hold.q_full   = q_full;
    assign hold.clearing = clearing;

    // Request intake and classification.
    wfba_front #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W),
        .QW         (QW)
    ) u_front (
        .start       (start),
        .func        (func),
        .block_index (block_index),
        .size        (size),
        .hold        (hold),
        .busy        (busy),
        .push        (push),
        .push_data   (push_data)
    );

    // Command queue between intake and execution.
    wfba_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Table, clearing pass and worst-fit scan.
    wfba_back #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W),
        .QW         (QW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .q_rdata      (q_rdata),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .done         (done),
        .status       (status),
        .chosen_block (chosen_block),
        .leftover     (leftover)
    );

    // Result without a grant, and result fields that are both clear.
    assign no_grant    = done && (status != ST_GRANTED);
    assign fields_zero = (chosen_block == '0) && (leftover == '0);

    // Requests are refused for the whole clearing pass.
    `WFBA_ASSERT_SAME(a_clear_holds_off, clearing, busy, "request possible while clearing")
    // The engine returns to idle between results, so strobes never abut.
    `WFBA_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    // Only a grant carries an index and a leftover.
    `WFBA_ASSERT_SAME(a_idle_fields_zero, no_grant, fields_zero, "nonzero fields without a grant")
    // The engine only takes commands that the queue holds.
    `WFBA_ASSERT_SAME(a_pop_nonempty, q_pop, !q_empty, "pop from an empty queue")

endmodule

// File: rtl/core/wfba_front.sv
// ----------------------------------------------------------------------------
// Worst-fit allocator front end
// Accepts requests, classifies them into load, ignored load or allocation,
// trims the fields to table widths and pushes them into the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfba_front #(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 5,
    parameter int QW         = 23
) (
    input  logic                         start,
    input  logic [wfba_pkg::FUNC_W-1:0]    func,
    input  logic [wfba_pkg::IDX_IN_W-1:0]  block_index,
    input  logic [wfba_pkg::SIZE_IN_W-1:0] size,
    input  wfba_pkg::hold_t              hold,
    output logic                         busy,
    output logic                         push,
    output logic [QW-1:0]                push_data
);
    import wfba_pkg::*;

    logic [31:0]          idx_wide;
    logic [31:0]          size_wide;
    logic                 in_table;
    op_t                  op;
    logic [IDX_W-1:0]     cmd_idx;
    logic [SIZE_BITS-1:0] cmd_size;

    // Hold off requests while the queue is full or the table is being cleared.
    assign busy = hold.q_full | hold.clearing;
    assign push = start & ~busy;

    // Bring the fields to the table's index and size widths.
    assign idx_wide  = 32'(block_index);
    assign size_wide = 32'(size);
    assign cmd_idx   = idx_wide[IDX_W-1:0];
    assign cmd_size  = size_wide[SIZE_BITS-1:0];
    assign in_table  = (idx_wide < 32'(NUM_BLOCKS));

    // Classify the request.
    always_comb
    begin
        if (func == FUNC_ALLOC)
        begin
            op = OP_ALLOC;
        end
        else if (in_table)
        begin
            op = OP_LOAD;
        end
        else
        begin
            op = OP_SKIP;
        end
    end

    assign push_data = {op, cmd_idx, cmd_size};

endmodule

// File: rtl/core/wfba_queue.sv
// ----------------------------------------------------------------------------
// Worst-fit allocator command queue
// Two-entry FIFO between the front end and the execution engine, so that
// a request can be taken while the engine is still scanning.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfba_queue #(
    parameter int WIDTH = 23
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    import wfba_pkg::*;

    logic [WIDTH-1:0] entry_reg [2];
    logic             wptr_reg;
    logic             wptr_next;
    logic             rptr_reg;
    logic             rptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = entry_reg[rptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wptr_next = do_push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/wfba_back.sv
// ----------------------------------------------------------------------------
// Worst-fit allocator execution engine
// Holds the block table, clears the used marks after reset, executes loads
// and scans the table one entry per cycle to find the worst fit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfba_back #(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 5,
    parameter int QW         = 23
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wfba_pkg::CFG_W-1:0]    cfg_data,
    input  logic [QW-1:0]                 q_rdata,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          done,
    output logic [wfba_pkg::STATUS_W-1:0] status,
    output logic [wfba_pkg::CHOSEN_W-1:0] chosen_block,
    output logic [wfba_pkg::LEFT_W-1:0]   leftover
);
    import wfba_pkg::*;

    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int MEM_W = SIZE_BITS + 1;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_WAIT     = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    // Table entry: used mark on top of the block size.
    logic [MEM_W-1:0]     mem [NUM_BLOCKS];
    logic [MEM_W-1:0]     rd_reg;
    logic                 rd_en;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [MEM_W-1:0]     mem_wdata;

    logic [2:0]           state_reg, state_next;
    logic [CFG_W-1:0]     bin_reg, bin_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    op_t                  op_reg, op_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_left_reg, best_left_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [CHOSEN_W-1:0]  chosen_reg, chosen_next;
    logic [LEFT_W-1:0]    left_reg, left_next;

    op_t                  q_op;
    logic [IDX_W-1:0]     q_idx;
    logic [SIZE_BITS-1:0] q_size;
    logic [LIM_W-1:0]     cfg_wide;
    logic [LIM_W-1:0]     lim_wide;
    logic                 scan_last;
    logic                 cand_used;
    logic [SIZE_BITS-1:0] cand_size;
    logic [SIZE_BITS-1:0] cand_left;
    logic                 cand_better;
    logic [31:0]          chosen_wide;
    logic [31:0]          left_wide;

    assign clearing     = (state_reg == S_CLEAR);
    assign done         = done_reg;
    assign status       = status_reg;
    assign chosen_block = chosen_reg;
    assign leftover     = left_reg;

    // Unpack the queued command.
    assign q_op   = q_rdata[QW-1 -: OP_W];
    assign q_idx  = q_rdata[SIZE_BITS +: IDX_W];
    assign q_size = q_rdata[SIZE_BITS-1:0];

    // Effective block count, saturated to the table depth.
    assign cfg_wide  = LIM_W'(bin_reg);
    assign lim_wide  = (cfg_wide > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : cfg_wide;
    assign scan_last = (LIM_W'(addr_reg) == (lim_wide - LIM_W'(1)));

    // Compare stage on the registered table read.
    assign cand_used   = rd_reg[SIZE_BITS];
    assign cand_size   = rd_reg[SIZE_BITS-1:0];
    assign cand_left   = cand_size - req_reg;
    assign cand_better = cmp_valid_reg && !cand_used && (cand_size >= req_reg) &&
                         (!found_reg || (cand_left > best_left_reg));

    assign chosen_wide = 32'(best_idx_reg);
    assign left_wide   = 32'(best_left_reg);

    // Engine sequencer.
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = cfg_we ? cfg_data : bin_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        cmp_valid_next = (state_reg == S_SCAN);
        cmp_idx_next   = addr_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_left_next = best_left_reg;
        best_size_next = best_size_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        chosen_next    = chosen_reg;
        left_next      = left_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;

        // Keep the best candidate seen so far.
        if (cand_better)
        begin
            found_next     = 1'b1;
            best_idx_next  = cmp_idx_reg;
            best_left_next = cand_left;
            best_size_next = cand_size;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_op;
                    idx_next   = q_idx;
                    req_next   = q_size;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                chosen_next = '0;
                left_next   = '0;
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = idx_reg;
                        mem_wdata   = {1'b0, req_reg};
                        done_next   = 1'b1;
                        status_next = ST_LOADED;
                        state_next  = S_IDLE;
                    end
                    OP_ALLOC:
                    begin
                        if (lim_wide == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOFIT;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            addr_next  = '0;
                            found_next = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        // A load outside the table only answers.
                        done_next   = 1'b1;
                        status_next = ST_LOADED;
                        state_next  = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                rd_en = 1'b1;
                if (scan_last)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            S_WAIT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (found_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = best_idx_reg;
                    mem_wdata   = {1'b1, best_size_reg};
                    status_next = ST_GRANTED;
                    chosen_next = chosen_wide[CHOSEN_W-1:0];
                    left_next   = left_wide[LEFT_W-1:0];
                end
                else
                begin
                    status_next = ST_NOFIT;
                    chosen_next = '0;
                    left_next   = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            bin_reg       <= CFG_RESET;
            clr_reg       <= '0;
            addr_reg      <= '0;
            op_reg        <= OP_SKIP;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= ST_LOADED;
            chosen_reg    <= '0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bin_reg       <= bin_next;
            clr_reg       <= clr_next;
            addr_reg      <= addr_next;
            op_reg        <= op_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            chosen_reg    <= chosen_next;
            left_reg      <= left_next;
        end
    end

    // Payload registers of the command and the scan.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        req_reg       <= req_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_left_reg <= best_left_next;
        best_size_reg <= best_size_next;
    end

    // Block table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

endmodule

// File: bench/worst_fit_block_allocator_checker.sv
// ----------------------------------------------------------------------------
// Worst-fit allocator reply checker
// Watches the request, configuration and reply ports of the allocator core.
// It keeps its own copy of the block table and block count, works out the
// reply each accepted request must get, and compares the replies in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module worst_fit_block_allocator_checker #(
    parameter int NUM_BLOCKS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [wfba_pkg::FUNC_W-1:0]    func,
    input  logic [wfba_pkg::IDX_IN_W-1:0]  block_index,
    input  logic [wfba_pkg::SIZE_IN_W-1:0] size,
    input  logic                           cfg_we,
    input  logic [wfba_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           done,
    input  logic [wfba_pkg::STATUS_W-1:0]  status,
    input  logic [wfba_pkg::CHOSEN_W-1:0]  chosen_block,
    input  logic [wfba_pkg::LEFT_W-1:0]    leftover,
    output int                             mismatches,
    output int                             pending
);
    import wfba_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [CHOSEN_W-1:0] block;
        logic [LEFT_W-1:0]   left;
    } reply_t;

    // Shadow copy of the block table and the block count register.
    logic [SIZE_IN_W-1:0] table_size  [NUM_BLOCKS];
    logic                 table_taken [NUM_BLOCKS];
    logic [CFG_W-1:0]     block_count;

    // Replies owed for accepted requests, oldest first.
    reply_t owed_replies [$];

    // Applies one request to the shadow table and returns the reply it earns.
    function automatic reply_t serve_request(logic [FUNC_W-1:0]    f,
                                             logic [IDX_IN_W-1:0]  idx,
                                             logic [SIZE_IN_W-1:0] amount);
        reply_t            r;
        int                limit;
        logic              found;
        logic [LEFT_W-1:0] best_left;
        logic [LEFT_W-1:0] spare;
        r = '{status: ST_LOADED, block: '0, left: '0};
        if (f == FUNC_LOAD) begin
            if (idx < NUM_BLOCKS) begin
                table_size[idx]  = amount;
                table_taken[idx] = 1'b0;
            end
            return r;
        end
        // A count above the table size only covers the whole table.
        limit     = (block_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count);
        found     = 1'b0;
        best_left = '0;
        for (int j = 0; j < limit; j++) begin
            if (!table_taken[j] && table_size[j] >= amount) begin
                spare = table_size[j] - amount;
                // Strictly larger, so the lowest index wins a tie.
                if (!found || spare > best_left) begin
                    found     = 1'b1;
                    r.block   = CHOSEN_W'(j);
                    best_left = spare;
                end
            end
        end
        if (found) begin
            table_taken[r.block] = 1'b1;
            r.status             = ST_GRANTED;
            r.left               = best_left;
        end else begin
            r.status = ST_NOFIT;
        end
        return r;
    endfunction

    task automatic note_fault(string what, reply_t want, reply_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s: expected status %0d block %0d leftover %0d,",
                     $time, what, want.status, want.block, want.left);
            $display("    got status %0d block %0d leftover %0d",
                     got.status, got.block, got.left);
        end
    endtask

    // Replies are checked before the request of the same edge is queued, since
    // a reply on this edge always belongs to an older request.
    always @(posedge clk or negedge rst_n) begin
        reply_t got;
        reply_t want;
        if (!rst_n) begin
            for (int j = 0; j < NUM_BLOCKS; j++) begin
                table_taken[j] = 1'b0;
            end
            block_count = CFG_RESET;
            owed_replies.delete();
            pending = 0;
        end else begin
            if (cfg_we) begin
                block_count = cfg_data;
            end
            if (done) begin
                got = '{status: status, block: chosen_block, left: leftover};
                if (owed_replies.size() == 0) begin
                    note_fault("reply with no request outstanding", '0, got);
                end else begin
                    want = owed_replies.pop_front();
                    if (got.status !== want.status || got.block !== want.block
                        || got.left !== want.left) begin
                        note_fault("reply mismatch", want, got);
                    end
                end
            end
            if (start && !busy) begin
                owed_replies.push_back(serve_request(func, block_index, size));
            end
            pending = owed_replies.size();
        end
    end

endmodule

// File: bench/worst_fit_block_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// Worst-fit allocator core testbench
// Drives directed and random load and allocate requests with random gaps
// through several block count settings. A checker beside the core predicts
// and compares every reply; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module worst_fit_block_allocator_core_tb;

    import wfba_pkg::*;

    localparam int NUM_BLOCKS      = 32;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int SETTLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_NS     = 5_000_000;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic [FUNC_W-1:0]    func         = FUNC_LOAD;
    logic [IDX_IN_W-1:0]  block_index  = '0;
    logic [SIZE_IN_W-1:0] size         = '0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 busy;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [CHOSEN_W-1:0]  chosen_block;
    logic [LEFT_W-1:0]    leftover;
    int                   mismatches;
    int                   pending;

    // Blocks whose size has been loaded; allocations never scan others.
    logic loaded [NUM_BLOCKS] = '{default: 1'b0};
    int   count_setting = CFG_RESET;
    int   phase_counts [8] = '{63, 32, 1, 33, 0, 31, 2, 32};

    always #5 clk = ~clk;

    worst_fit_block_allocator_core #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_BITS (16)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .block_index (block_index),
        .size        (size),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .chosen_block(chosen_block),
        .leftover    (leftover)
    );

    worst_fit_block_allocator_checker #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .block_index (block_index),
        .size        (size),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .chosen_block(chosen_block),
        .leftover    (leftover),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Presents one request at a falling edge and returns at the falling edge
    // after it was taken. Start is left high so a back-to-back request follows.
    task automatic send_request(logic [FUNC_W-1:0]    f,
                                logic [IDX_IN_W-1:0]  idx,
                                logic [SIZE_IN_W-1:0] amount);
        start       <= 1'b1;
        func        <= f;
        block_index <= idx;
        size        <= amount;
        if (f == FUNC_LOAD) begin
            loaded[idx] = 1'b1;
        end
        // Busy only moves on rising edges, so its value here holds until the next.
        while (busy) begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    task automatic idle_for(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // The count is only changed once every reply is in and the core is free.
    task automatic write_block_count(int value);
        start <= 1'b0;
        while (pending != 0 || busy) begin
            @(negedge clk);
        end
        cfg_we   <= 1'b1;
        cfg_data <= CFG_W'(value);
        @(negedge clk);
        cfg_we        <= 1'b0;
        count_setting = value;
    endtask

    // Mostly no gap, often a short gap and a few long pauses.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 60);
    endfunction

    // Extremes and a small set of round values give ties and exact fits.
    function automatic logic [SIZE_IN_W-1:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return SIZE_IN_W'($urandom_range(0, 7) * 16);
            default: return SIZE_IN_W'($urandom);
        endcase
    endfunction

    // Loads fill any unloaded block in range first; after that loads refill
    // blocks, half of them picked inside a nonempty active range, and allocations drain them.
    task automatic random_request();
        int                  active;
        int                  hole;
        logic [IDX_IN_W-1:0] idx;
        active = (count_setting > NUM_BLOCKS) ? NUM_BLOCKS : count_setting;
        hole   = -1;
        for (int j = active - 1; j >= 0; j--) begin
            if (!loaded[j]) begin
                hole = j;
            end
        end
        if (hole < 0 && $urandom_range(0, 99) < 55) begin
            send_request(FUNC_ALLOC, IDX_IN_W'($urandom), pick_size());
        end else begin
            if (hole >= 0) begin
                idx = IDX_IN_W'(hole);
            end else if (active > 0 && $urandom_range(0, 1) == 1) begin
                idx = IDX_IN_W'($urandom_range(0, active - 1));
            end else begin
                idx = IDX_IN_W'($urandom);
            end
            send_request(FUNC_LOAD, idx, pick_size());
        end
    endtask

    initial begin
        logic no_gaps;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Four-block table: extremes, ties, exact fits and running out.
        write_block_count(4);
        send_request(FUNC_LOAD, 5'd0, 16'd0);
        send_request(FUNC_LOAD, 5'd1, 16'hFFFF);
        send_request(FUNC_LOAD, 5'd2, 16'd100);
        send_request(FUNC_LOAD, 5'd3, 16'd100);
        send_request(FUNC_ALLOC, 5'd0, 16'd0);
        send_request(FUNC_ALLOC, 5'd0, 16'hFFFF);
        send_request(FUNC_ALLOC, 5'd0, 16'd100);
        idle_for(3);
        send_request(FUNC_ALLOC, 5'd0, 16'd0);
        send_request(FUNC_ALLOC, 5'd0, 16'd0);
        send_request(FUNC_ALLOC, 5'd0, 16'd0);
        // Reloading a taken block frees it again.
        send_request(FUNC_LOAD, 5'd1, 16'hFFFF);
        send_request(FUNC_ALLOC, 5'd0, 16'hFFFF);
        // A block past the active count is never offered.
        send_request(FUNC_LOAD, 5'd31, 16'h5555);
        send_request(FUNC_LOAD, 5'd3, 16'hAAAA);
        send_request(FUNC_ALLOC, 5'd31, 16'hAAAA);
        send_request(FUNC_ALLOC, 5'd31, 16'd1);

        // A count of zero offers nothing.
        write_block_count(0);
        send_request(FUNC_ALLOC, 5'd0, 16'd0);
        send_request(FUNC_ALLOC, 5'd0, 16'h5555);

        // Random phases across count settings, including ones past the table.
        for (int p = 0; p < 8; p++) begin
            write_block_count(p == 6 ? $urandom_range(0, 63) : phase_counts[p]);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) begin
                if (!no_gaps) begin
                    idle_for(pick_gap());
                end
                random_request();
            end
        end

        start <= 1'b0;
        for (int n = 0; n < SETTLE_LIMIT && pending != 0; n++) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("worst_fit_block_allocator_core regression: pass");
        end else begin
            $display("worst_fit_block_allocator_core regression: fail");
        end
        $finish;
    end

    // Guards against a hung handshake.
    initial begin
        #(WATCHDOG_NS);
        $display("worst_fit_block_allocator_core regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/wfba_pkg.sv
rtl/core/wfba_front.sv
rtl/core/wfba_queue.sv
rtl/core/wfba_back.sv
rtl/core/worst_fit_block_allocator_core.sv
bench/worst_fit_block_allocator_checker.sv
bench/worst_fit_block_allocator_core_tb.sv
